>>> sv/sha256_message_digest_assert.svh
// Assertion macros used by the top module of the digest block.
`ifndef SHA256_MESSAGE_DIGEST_ASSERT_SVH
`define SHA256_MESSAGE_DIGEST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define S256MD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define S256MD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/s256md_pkg.sv
`timescale 1ns / 1ps

package s256md_pkg;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [3:0] LEN_HI_IDX = 4'd14;
    localparam logic [3:0] LEN_LO_IDX = 4'd15;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [5:0] LEN_POS    = 6'd55;
    localparam logic [7:0] LAST_STEP  = 8'd129;
    localparam logic [3:0] HASH_DONE  = 4'd8;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            3'd7:    v = 32'h5be0cd19;
            default: v = 32'h6a09e667;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
            default: k = 32'h428a2f98;
        endcase
        return k;
    endfunction

endpackage

>>> sv/s256md_in_if.sv
`timescale 1ns / 1ps

interface s256md_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, msg_byte, has_byte, end_of_message, input ready);
    modport sink (input valid, msg_byte, has_byte, end_of_message, output ready);
endinterface

>>> sv/s256md_out_if.sv
`timescale 1ns / 1ps

interface s256md_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;

    modport source (output valid, digest_word, word_index, final_word, input ready);
    modport sink (input valid, digest_word, word_index, final_word, output ready);
endinterface

>>> sv/sha256_message_digest.sv
`timescale 1ns / 1ps
`include "sha256_message_digest_assert.svh"

// SHA-256 over a byte stream. A transaction with has_byte set appends one byte;
// the byte that completes a 64-byte block starts a compression that loads the
// hash words from memory, primes the schedule reads, runs the 64 rounds (their
// pace is set by the two read ports of the 16-word block memory that holds the
// rolling message schedule) and writes the hash back. A transaction with
// end_of_message set pads one byte per cycle, pausing while a compression runs,
// writes the 64-bit length, runs one or two compressions and then delivers the
// eight digest words, H0 first, each once the one before it has been taken.
// The hash state sits in an 8-word memory whose entries read as the initial
// values until rewritten, so the block accepts its first item right after reset.
module sha256_message_digest import s256md_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    s256md_in_if.sink    i_msg,
    s256md_out_if.source o_digest
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_PAD    = 9'b000000010,
        ST_LEN_HI = 9'b000000100,
        ST_LEN_LO = 9'b000001000,
        ST_LOAD   = 9'b000010000,
        ST_ROUND  = 9'b000100000,
        ST_HADD   = 9'b001000000,
        ST_OUT_RD = 9'b010000000,
        ST_OUT_LD = 9'b100000000
    } t_state;

    t_state      r_state;
    logic [5:0]  r_pos;
    logic [63:0] r_bc;
    logic [7:0]  r_hvld;
    logic        r_pad_first;
    logic        r_pad_pend;
    logic        r_last;
    logic        r_ovld;
    logic [3:0]  r_cnt;
    logic [7:0]  r_step;

    logic [31:0] r_acc;
    logic [31:0] r_wk [8];
    logic [31:0] r_w;
    logic [31:0] r_s;
    logic        r_hrd_vld;
    logic [2:0]  r_hrd_idx;
    logic [31:0] r_out_word;
    logic [2:0]  r_out_idx;
    logic        r_out_final;

    logic             in_take;
    logic             out_take;
    logic             push;
    logic [7:0]       push_byte;
    logic [31:0]      push_word;
    logic             blk_full;

    logic             w_we;
    logic [3:0]       w_wr_addr;
    logic [31:0]      w_wr_data;
    logic [1:0][3:0]  w_rd_addr;
    logic [1:0][31:0] w_rd_data;

    logic             h_we;
    logic [2:0]       h_wr_addr;
    logic [31:0]      h_wr_data;
    logic [31:0]      h_rd_data;
    logic [31:0]      hash_q;
    logic [2:0]       cnt_prev;

    logic [3:0]       t4;
    logic [6:0]       tw;
    logic             sched_new;
    logic [31:0]      w_cur;
    logic             step_even;
    logic [31:0]      t1;
    logic [31:0]      t2;
    logic [31:0]      ch;
    logic [31:0]      maj;

    assign in_take  = i_msg.valid && i_msg.ready;
    assign out_take = o_digest.valid && o_digest.ready;
    assign i_msg.ready = (r_state == ST_IDLE);

    assign o_digest.valid       = r_ovld;
    assign o_digest.digest_word = r_out_word;
    assign o_digest.word_index  = r_out_idx;
    assign o_digest.final_word  = r_out_final;

    // Bytes enter a word accumulator; a word goes to memory on its last lane.
    assign push      = (in_take && i_msg.has_byte) || (r_state == ST_PAD);
    assign push_byte = (r_state == ST_PAD) ? (r_pad_first ? PAD_BYTE : 8'h00)
                                           : i_msg.msg_byte;
    assign push_word = {r_acc[23:0], push_byte};
    assign blk_full  = (r_pos == LAST_POS);

    // Schedule indexing: even steps read w[t-15] and w[t-2], odd steps read
    // w[t-16] and w[t-7]; word t-1 is produced on the even step of round t.
    assign step_even = ~r_step[0];
    assign t4        = r_step[4:1];
    assign tw        = r_step[7:1] - 7'd1;
    assign sched_new = (tw >= 7'd16);
    assign w_cur     = sched_new ? (w_rd_data[0] + w_rd_data[1] + r_s) : w_rd_data[0];

    always_comb begin
        if (step_even) begin
            w_rd_addr[0] = t4 + 4'd1;
            w_rd_addr[1] = t4 - 4'd2;
        end else begin
            w_rd_addr[0] = t4;
            w_rd_addr[1] = t4 + 4'd9;
        end
    end

    always_comb begin
        w_we      = 1'b0;
        w_wr_addr = r_pos[5:2];
        w_wr_data = push_word;
        case (r_state)
            ST_IDLE, ST_PAD: begin
                w_we = push && (r_pos[1:0] == 2'd3);
            end
            ST_LEN_HI: begin
                w_we      = 1'b1;
                w_wr_addr = LEN_HI_IDX;
                w_wr_data = r_bc[63:32];
            end
            ST_LEN_LO: begin
                w_we      = 1'b1;
                w_wr_addr = LEN_LO_IDX;
                w_wr_data = r_bc[31:0];
            end
            ST_ROUND: begin
                w_we      = step_even && (r_step != 8'd0) && sched_new;
                w_wr_addr = tw[3:0];
                w_wr_data = w_cur;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    s256md_ram #(
        .WIDTH (32),
        .DEPTH (16),
        .N_RD  (2)
    ) u_block_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // The hash memory is read at r_cnt every cycle; entries not yet written
    // since the last digest read as the initial hash values.
    assign cnt_prev  = r_cnt[2:0] - 3'd1;
    assign hash_q    = r_hrd_vld ? h_rd_data : init_hash(r_hrd_idx);
    assign h_we      = (r_state == ST_HADD) && (r_cnt != 4'd0);
    assign h_wr_addr = cnt_prev;
    assign h_wr_data = hash_q + r_wk[cnt_prev];

    s256md_ram #(
        .WIDTH (32),
        .DEPTH (8),
        .N_RD  (1)
    ) u_hash_ram (
        .i_clk     (i_clk),
        .i_we      (h_we),
        .i_wr_addr (h_wr_addr),
        .i_wr_data (h_wr_data),
        .i_rd_addr (r_cnt[2:0]),
        .o_rd_data (h_rd_data)
    );

    assign ch  = (r_wk[4] & r_wk[5]) ^ (~r_wk[4] & r_wk[6]);
    assign maj = (r_wk[0] & r_wk[1]) ^ (r_wk[0] & r_wk[2]) ^ (r_wk[1] & r_wk[2]);
    assign t1  = r_wk[7] + big_sigma1(r_wk[4]) + ch + round_const(tw[5:0]) + r_w;
    assign t2  = big_sigma0(r_wk[0]) + maj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= 6'd0;
            r_bc        <= 64'd0;
            r_hvld      <= 8'd0;
            r_pad_first <= 1'b0;
            r_pad_pend  <= 1'b0;
            r_last      <= 1'b0;
            r_ovld      <= 1'b0;
            r_cnt       <= 4'd0;
            r_step      <= 8'd0;
        end else begin
            if (out_take) begin
                r_ovld <= 1'b0;
            end
            if (push) begin
                r_pos <= r_pos + 6'd1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_take) begin
                        if (i_msg.has_byte) begin
                            r_bc <= r_bc + 64'd8;
                        end
                        if (i_msg.end_of_message) begin
                            r_pad_first <= 1'b1;
                            r_pad_pend  <= 1'b1;
                        end
                        if (i_msg.has_byte && blk_full) begin
                            r_cnt   <= 4'd0;
                            r_state <= ST_LOAD;
                        end else if (i_msg.end_of_message) begin
                            r_state <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    r_pad_first <= 1'b0;
                    if (blk_full) begin
                        r_cnt   <= 4'd0;
                        r_state <= ST_LOAD;
                    end else if (r_pos == LEN_POS) begin
                        r_state <= ST_LEN_HI;
                    end
                end
                ST_LEN_HI: begin
                    r_state <= ST_LEN_LO;
                end
                ST_LEN_LO: begin
                    r_last     <= 1'b1;
                    r_pad_pend <= 1'b0;
                    r_cnt      <= 4'd0;
                    r_state    <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == HASH_DONE) begin
                        r_step  <= 8'd0;
                        r_state <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    r_step <= r_step + 8'd1;
                    if (r_step == LAST_STEP) begin
                        r_cnt   <= 4'd0;
                        r_state <= ST_HADD;
                    end
                end
                ST_HADD: begin
                    if (r_cnt != 4'd0) begin
                        r_hvld[cnt_prev] <= 1'b1;
                    end
                    if (r_cnt == HASH_DONE) begin
                        r_cnt <= 4'd0;
                        if (r_last) begin
                            r_state <= ST_OUT_RD;
                        end else if (r_pad_pend) begin
                            r_state <= ST_PAD;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                ST_OUT_RD: begin
                    if (!r_ovld || out_take) begin
                        r_state <= ST_OUT_LD;
                    end
                end
                ST_OUT_LD: begin
                    r_ovld <= 1'b1;
                    if (r_cnt[2:0] == LAST_WORD) begin
                        r_hvld  <= 8'd0;
                        r_bc    <= 64'd0;
                        r_pos   <= 6'd0;
                        r_last  <= 1'b0;
                        r_cnt   <= 4'd0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_cnt   <= r_cnt + 4'd1;
                        r_state <= ST_OUT_RD;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_hrd_vld <= r_hvld[r_cnt[2:0]];
        r_hrd_idx <= r_cnt[2:0];
        if (push) begin
            r_acc <= push_word;
        end
        if ((r_state == ST_LOAD) && (r_cnt != 4'd0)) begin
            r_wk[cnt_prev] <= hash_q;
        end
        if (r_state == ST_ROUND) begin
            if (step_even) begin
                r_w <= w_cur;
            end else begin
                r_s <= small_sigma0(w_rd_data[0]) + small_sigma1(w_rd_data[1]);
                if (r_step >= 8'd3) begin
                    r_wk[7] <= r_wk[6];
                    r_wk[6] <= r_wk[5];
                    r_wk[5] <= r_wk[4];
                    r_wk[4] <= r_wk[3] + t1;
                    r_wk[3] <= r_wk[2];
                    r_wk[2] <= r_wk[1];
                    r_wk[1] <= r_wk[0];
                    r_wk[0] <= t1 + t2;
                end
            end
        end
        if (r_state == ST_OUT_LD) begin
            r_out_word  <= hash_q;
            r_out_idx   <= r_cnt[2:0];
            r_out_final <= (r_cnt[2:0] == LAST_WORD);
        end
    end

    `S256MD_ASSERT_SAME(a_out_slot_free, r_state == ST_OUT_LD, !r_ovld,
        "digest register still occupied")
    `S256MD_ASSERT_SAME(a_hash_all_or_none, r_state == ST_IDLE,
        (r_hvld == 8'd0) || (r_hvld == 8'hff), "hash memory partly rewritten while idle")
    `S256MD_ASSERT_SAME(a_round_bound, r_state == ST_ROUND, r_step <= LAST_STEP,
        "round step counter overran")
    `S256MD_ASSERT_NEXT(a_len_then_load, r_state == ST_LEN_LO, (r_state == ST_LOAD) && r_last,
        "length block did not start the last compression")

endmodule

>>> sv/s256md_ram.sv
`timescale 1ns / 1ps

module s256md_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int N_RD   = 1,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [ADDR_W-1:0]            i_wr_addr,
    input  logic [WIDTH-1:0]             i_wr_data,
    input  logic [N_RD-1:0][ADDR_W-1:0]  i_rd_addr,
    output logic [N_RD-1:0][WIDTH-1:0]   o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // A read of the entry written in the same cycle returns the old data.
    for (genvar g = 0; g < N_RD; g++) begin : g_rd
        always_ff @(posedge i_clk) begin
            o_rd_data[g] <= r_mem[i_rd_addr[g]];
        end
    end

endmodule
